@@ sv/bms_frame_parser_top_defines.svh @@
// assertion macros for the bms frame parser
// used by bms_frame_parser_top; expects aclk and aresetn in scope
`ifndef BMS_FRAME_PARSER_TOP_DEFINES_SVH
`define BMS_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef SYNTH
`define BFP_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bfp check failed");
`define BFP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bfp reset check failed");
`else
`define BFP_ASSERT(label, prop)
`define BFP_ASSERT_RST(label, prop)
`endif

`endif

@@ sv/bfp_pkg.sv @@
// shared types and constants for the bms frame parser
// no dependencies
`timescale 1ns / 1ps

package bfp_pkg;

    localparam logic [7:0] LEAD_MARK = 8'hDD;
    localparam logic [7:0] STOP_MARK = 8'h77;
    localparam int MIN_FRAME  = 7;
    localparam int MIN_STOP   = 3;
    localparam int POS_LEAD   = 0;
    localparam int POS_VOLT_H = 4;
    localparam int POS_VOLT_L = 5;
    localparam int POS_CURR_H = 6;
    localparam int POS_CURR_L = 7;
    localparam int POS_SOC    = 4 + 9 * 2 + 1;

    localparam int OUT_DATA_W = 48;

    // readings of one accepted frame
    typedef struct packed {
        logic [7:0]  soc;
        logic [15:0] current;
        logic [15:0] voltage;
    } bfp_frame_t;

    // per-byte decision of the collector
    typedef struct packed {
        logic frame_end;
        logic frame_ok;
    } bfp_ctl_t;

endpackage

@@ sv/bms_frame_parser_top.sv @@
// Receive-side frame parser for a battery management serial link. One byte is
// taken per transfer on the slave side, one every clock cycle when the master
// side keeps up; each byte passes an input register, and the stop byte of an
// accepted frame loads the result register from it. A result holds, from the
// lowest bit: voltage (16), signed current (20), charge percent (8), charging
// flag (1), zero padded to 48 bits. The slave side stalls only while a byte
// that completes a valid frame waits for the result register to drain.
// depends on bfp_pkg, bfp_collect, bfp_out_stage and the defines header
`timescale 1ns / 1ps
`include "bms_frame_parser_top_defines.svh"

module bms_frame_parser_top #(
    parameter int FRAME_BUF = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // voltage_10mv [15:0], current_value [35:16], charge_percent [43:36],
    // charging [44], zero [47:45]
    output logic [47:0] m_tdata
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               proc;
    logic               out_free;
    bfp_pkg::bfp_ctl_t  ctl;
    bfp_pkg::bfp_frame_t frame;

    assign proc     = in_valid_reg && (!ctl.frame_ok || out_free);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    bfp_collect #(
        .FRAME_BUF(FRAME_BUF)
    ) u_collect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (proc),
        .rx_byte (in_byte_reg),
        .ctl     (ctl),
        .frame   (frame)
    );

    bfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc && ctl.frame_ok),
        .frame    (frame),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a result enters the output register when a good frame ends
    `BFP_ASSERT(a_result_loaded, proc && ctl.frame_ok |=> m_tvalid)
    // a new result only follows a completed good frame
    `BFP_ASSERT(a_result_source, $rose(m_tvalid) |-> $past(proc && ctl.frame_ok))
    // charging is never flagged together with a negative current
    `BFP_ASSERT(a_charging_sign, m_tvalid && m_tdata[44] |-> !m_tdata[35])
    // reset leaves no result and no pending byte
    `BFP_ASSERT_RST(a_reset_clear, !aresetn |=> !m_tvalid && s_tready)

endmodule

@@ sv/bfp_collect.sv @@
// frame collector: byte counter, fixed-offset captures and held readings
// depends on bfp_pkg
`timescale 1ns / 1ps

module bfp_collect #(
    parameter int FRAME_BUF = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [7:0]          rx_byte,
    output bfp_pkg::bfp_ctl_t   ctl,
    output bfp_pkg::bfp_frame_t frame
);

    localparam int CW = $clog2(FRAME_BUF);
    localparam int LW = $clog2(FRAME_BUF + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] len;
    logic [7:0]    lead_reg, lead_next;
    bfp_pkg::bfp_frame_t staged_reg, staged_next;
    bfp_pkg::bfp_frame_t held_reg, held_next;

    assign len = LW'(cnt_reg) + LW'(1);

    // capture of the current byte at its offset
    always_comb begin
        lead_next   = lead_reg;
        staged_next = staged_reg;
        if (cnt_reg == CW'(bfp_pkg::POS_LEAD)) begin
            lead_next = rx_byte;
        end
        if (cnt_reg == CW'(bfp_pkg::POS_VOLT_H)) begin
            staged_next.voltage[15:8] = rx_byte;
        end
        if (cnt_reg == CW'(bfp_pkg::POS_VOLT_L)) begin
            staged_next.voltage[7:0] = rx_byte;
        end
        if (cnt_reg == CW'(bfp_pkg::POS_CURR_H)) begin
            staged_next.current[15:8] = rx_byte;
        end
        if (cnt_reg == CW'(bfp_pkg::POS_CURR_L)) begin
            staged_next.current[7:0] = rx_byte;
        end
        if (cnt_reg == CW'(bfp_pkg::POS_SOC)) begin
            staged_next.soc = rx_byte;
        end
    end

    always_comb begin
        ctl.frame_end = (len >= LW'(bfp_pkg::MIN_STOP)) && (rx_byte == bfp_pkg::STOP_MARK);
        ctl.frame_ok  = ctl.frame_end && (len >= LW'(bfp_pkg::MIN_FRAME))
                        && (lead_reg == bfp_pkg::LEAD_MARK);
    end

    // merge offsets that this frame reached into the held readings
    always_comb begin
        held_next = held_reg;
        if (len > LW'(bfp_pkg::POS_VOLT_H)) begin
            held_next.voltage[15:8] = staged_next.voltage[15:8];
        end
        if (len > LW'(bfp_pkg::POS_VOLT_L)) begin
            held_next.voltage[7:0] = staged_next.voltage[7:0];
        end
        if (len > LW'(bfp_pkg::POS_CURR_H)) begin
            held_next.current[15:8] = staged_next.current[15:8];
        end
        if (len > LW'(bfp_pkg::POS_CURR_L)) begin
            held_next.current[7:0] = staged_next.current[7:0];
        end
        if (len > LW'(bfp_pkg::POS_SOC)) begin
            held_next.soc = staged_next.soc;
        end
    end

    always_comb begin
        if (ctl.frame_end || len >= LW'(FRAME_BUF)) begin
            cnt_next = '0;
        end else begin
            cnt_next = len[CW-1:0];
        end
    end

    assign frame = held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            lead_reg   <= '0;
            staged_reg <= '0;
            held_reg   <= '0;
        end else if (byte_en) begin
            cnt_reg    <= cnt_next;
            lead_reg   <= lead_next;
            staged_reg <= staged_next;
            if (ctl.frame_ok) begin
                held_reg <= held_next;
            end
        end
    end

endmodule

@@ sv/bfp_out_stage.sv @@
// result register: scales the current and holds one result for the master side
// depends on bfp_pkg
`timescale 1ns / 1ps

module bfp_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  bfp_pkg::bfp_frame_t                 frame,
    output logic                                out_free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bfp_pkg::OUT_DATA_W-1:0]      m_tdata
);

    logic               valid_reg;
    logic [44:0]        data_reg, data_next;
    logic signed [19:0] cur_ext;
    logic signed [19:0] cur_val;
    logic               charging;

    assign cur_ext  = 20'(signed'(frame.current));
    // times ten for negative raw current
    assign cur_val  = frame.current[15] ? ((cur_ext <<< 3) + (cur_ext <<< 1)) : cur_ext;
    assign charging = !frame.current[15] && (frame.current != 16'd0);

    assign data_next = {charging, frame.soc, cur_val, frame.voltage};
    assign out_free  = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, data_reg};

endmodule
